### rtl/dcfp_pkg.sv
// Shared types and constants of the delimited command frame parser.
`timescale 1ns / 1ps
package dcfp_pkg;

  // Store capacities in bytes; the last entry of each store always stays zero.
  localparam int CMD_CAP = 16;
  localparam int VAL_CAP = 8;
  localparam int CMD_AW  = $clog2(CMD_CAP);
  localparam int VAL_AW  = $clog2(VAL_CAP);
  localparam int ADDR_W  = (CMD_AW > VAL_AW) ? CMD_AW : VAL_AW;

  // Depth of the operation queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_SEP   = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_VAL   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_WR_CMD,
    OP_WR_VAL,
    OP_CLEAR,
    OP_EMIT
  } op_code_t;

  typedef struct packed {
    op_code_t          code;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } op_t;

endpackage

### rtl/delimited_command_frame_parser.sv
// Top level of the delimited command frame parser.
// Throughput: one ordinary byte per cycle while the queue has room; the back part retires one
// store write or clear per cycle while idle. An end byte holds the back part until its message
// of at most 22 string bytes has gone out; output stalls lengthen the hold.
// Reset (synchronous, active high) restores the default delimiters, empties both stores and
// the queue, and leaves the parser idle; it is usable on the next cycle.
`timescale 1ns / 1ps
module delimited_command_frame_parser
  import dcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // The front decides, per input transaction, which store operation the byte
  // stands for (write to the command or value store, clear both, or emit the
  // message) and keeps the parse mode and fill counts itself. The operations
  // wait in a short queue, so the front keeps taking bytes while the back is
  // busy sending a message or held by a stalled output transaction.
  logic q_push;
  op_t  q_push_op;
  logic q_full;
  logic q_pop;
  op_t  q_pop_op;
  logic q_empty;

  dcfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_push_op)
  );

  dcfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_pop_op),
    .empty   (q_empty)
  );

  // The back owns the stores. Each store has a valid bit per entry, so a
  // clear resets them all at once and unwritten entries read as zero. Messages
  // are sent through an output register, so one transaction can wait on a stall
  // while the next byte is already read.
  dcfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_op      (q_pop_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

### rtl/dcfp_front.sv
// Front part: holds the delimiter registers, classifies bytes and tracks mode and fills.
`timescale 1ns / 1ps
module dcfp_front
  import dcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_CMD,
    M_VAL
  } mode_t;

  logic [7:0]        start_char;
  logic [7:0]        sep_char;
  logic [7:0]        end_char;
  mode_t             mode;
  mode_t             mode_next;
  logic [CMD_AW-1:0] cmd_fill;
  logic [CMD_AW-1:0] cmd_fill_next;
  logic [VAL_AW-1:0] val_fill;
  logic [VAL_AW-1:0] val_fill_next;
  logic              accept;
  logic              cmd_room;
  logic              val_room;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cmd_room = cmd_fill < CMD_AW'(CMD_CAP - 1);
  assign val_room = val_fill < VAL_AW'(VAL_CAP - 1);

  // The end byte wins over every other role; a start byte overrides any store.
  always_comb begin
    mode_next     = mode;
    cmd_fill_next = cmd_fill;
    val_fill_next = val_fill;
    q_push        = 1'b0;
    q_op.code     = OP_EMIT;
    q_op.addr     = '0;
    q_op.data     = rx_byte;
    if (rx_byte == end_char) begin
      mode_next     = M_IDLE;
      cmd_fill_next = '0;
      val_fill_next = '0;
      q_push        = 1'b1;
    end else if (rx_byte == start_char) begin
      mode_next     = M_CMD;
      cmd_fill_next = '0;
      val_fill_next = '0;
      q_push        = 1'b1;
      q_op.code     = OP_CLEAR;
    end else begin
      if (rx_byte == sep_char) begin
        mode_next = M_VAL;
      end
      if (mode == M_VAL && val_room) begin
        val_fill_next = val_fill + VAL_AW'(1);
        q_push        = 1'b1;
        q_op.code     = OP_WR_VAL;
        q_op.addr     = ADDR_W'(val_fill);
      end else if (mode == M_CMD && rx_byte != sep_char && cmd_room) begin
        cmd_fill_next = cmd_fill + CMD_AW'(1);
        q_push        = 1'b1;
        q_op.code     = OP_WR_CMD;
        q_op.addr     = ADDR_W'(cmd_fill);
      end
    end
    q_push = q_push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= 8'd35;
      sep_char   <= 8'd58;
      end_char   <= 8'd64;
      mode       <= M_IDLE;
      cmd_fill   <= '0;
      val_fill   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START: start_char <= cfg_data;
          REG_SEP:   sep_char   <= cfg_data;
          REG_END:   end_char   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        mode     <= mode_next;
        cmd_fill <= cmd_fill_next;
        val_fill <= val_fill_next;
      end
    end
  end

endmodule

### rtl/dcfp_queue.sv
// Short operation queue between the front and the back.
`timescale 1ns / 1ps
module dcfp_queue
  import dcfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  pop_op,
  output logic empty
);

  op_t             slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == (Q_AW + 1)'(Q_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (Q_AW + 1)'(1);
        2'b01:   count <= count - (Q_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/dcfp_back.sv
// Back part: owns both string stores, carries out writes and clears, and emits messages.
`timescale 1ns / 1ps
module dcfp_back
  import dcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  op_t        q_op,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMD,
    B_VAL,
    B_FIN
  } bstate_t;

  bstate_t           state;
  logic [7:0]        cmd_mem [CMD_CAP];
  logic [7:0]        val_mem [VAL_CAP];
  logic [CMD_CAP-1:0] cmd_vld;
  logic [VAL_CAP-1:0] val_vld;
  logic [7:0]        cmd_rd;
  logic [7:0]        val_rd;
  logic              cmd_vld_r;
  logic              val_vld_r;
  logic [CMD_AW-1:0] cmd_idx;
  logic [CMD_AW-1:0] cmd_idx_next;
  logic [VAL_AW-1:0] val_idx;
  logic [VAL_AW-1:0] val_idx_next;
  logic [7:0]        cmd_elem;
  logic [7:0]        val_elem;
  logic              held_v;
  logic [1:0]        held_kind;
  logic [7:0]        held_byte;
  logic              out_free;
  logic              step_ok;
  logic              op_take;

  // An entry never written since the last clear reads as zero.
  assign cmd_elem = cmd_vld_r ? cmd_rd : 8'd0;
  assign val_elem = val_vld_r ? val_rd : 8'd0;
  assign out_free = !out_valid || !out_stall;
  assign step_ok  = !held_v || out_free;
  assign op_take  = (state == B_IDLE) && !q_empty;
  assign q_pop    = op_take;

  // The read address is the next index, so the registered read data is
  // fresh for the current index on every cycle.
  always_comb begin
    cmd_idx_next = cmd_idx;
    val_idx_next = val_idx;
    case (state)
      B_IDLE: begin
        if (op_take && q_op.code == OP_EMIT) begin
          cmd_idx_next = '0;
          val_idx_next = '0;
        end
      end
      B_CMD: begin
        if (cmd_elem != 8'd0 && step_ok) begin
          cmd_idx_next = cmd_idx + CMD_AW'(1);
        end
      end
      B_VAL: begin
        if (val_elem != 8'd0 && step_ok) begin
          val_idx_next = val_idx + VAL_AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op_take && q_op.code == OP_WR_CMD) begin
      cmd_mem[q_op.addr[CMD_AW-1:0]] <= q_op.data;
    end
    if (op_take && q_op.code == OP_WR_VAL) begin
      val_mem[q_op.addr[VAL_AW-1:0]] <= q_op.data;
    end
    cmd_rd <= cmd_mem[cmd_idx_next];
    val_rd <= val_mem[val_idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld   <= '0;
      val_vld   <= '0;
      cmd_vld_r <= 1'b0;
      val_vld_r <= 1'b0;
    end else begin
      if (op_take) begin
        case (q_op.code)
          OP_WR_CMD: cmd_vld[q_op.addr[CMD_AW-1:0]] <= 1'b1;
          OP_WR_VAL: val_vld[q_op.addr[VAL_AW-1:0]] <= 1'b1;
          OP_CLEAR: begin
            cmd_vld <= '0;
            val_vld <= '0;
          end
          default: ;
        endcase
      end
      cmd_vld_r <= cmd_vld[cmd_idx_next];
      val_vld_r <= val_vld[val_idx_next];
    end
  end

  // One item is held back so that the final item of a message can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
      cmd_idx   <= '0;
      val_idx   <= '0;
    end else begin
      cmd_idx <= cmd_idx_next;
      val_idx <= val_idx_next;
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (op_take && q_op.code == OP_EMIT) begin
            state  <= B_CMD;
            held_v <= 1'b0;
          end
        end
        B_CMD: begin
          if (cmd_elem == 8'd0) begin
            state <= B_VAL;
          end else if (step_ok) begin
            if (held_v) begin
              out_valid <= 1'b1;
              out_kind  <= held_kind;
              out_byte  <= held_byte;
              out_last  <= 1'b0;
            end
            held_v    <= 1'b1;
            held_kind <= KIND_CMD;
            held_byte <= cmd_elem;
          end
        end
        B_VAL: begin
          if (val_elem == 8'd0) begin
            state <= B_FIN;
          end else if (step_ok) begin
            if (held_v) begin
              out_valid <= 1'b1;
              out_kind  <= held_kind;
              out_byte  <= held_byte;
              out_last  <= 1'b0;
            end
            held_v    <= 1'b1;
            held_kind <= KIND_VAL;
            held_byte <= val_elem;
          end
        end
        B_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            if (held_v) begin
              out_kind <= held_kind;
              out_byte <= held_byte;
            end else begin
              out_kind <= KIND_EMPTY;
              out_byte <= 8'd0;
            end
            held_v <= 1'b0;
            state  <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/delimited_command_frame_parser_test.sv
// Self-checking testbench for the delimited command frame parser.
`timescale 1ns / 1ps

// Parser state as the predictor tracks it.
typedef enum logic [1:0] {
  PARSE_IDLE,
  PARSE_CMD,
  PARSE_VAL
} parse_mode_t;

// One result transaction as it should leave the block.
typedef struct {
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;
} emit_t;

// Predicts the strings that each end byte releases and checks the block's output against them.
class emit_predictor;
  logic [7:0]  start_c;
  logic [7:0]  sep_c;
  logic [7:0]  end_c;
  logic [7:0]  cmd_mem [dcfp_pkg::CMD_CAP];
  logic [7:0]  val_mem [dcfp_pkg::VAL_CAP];
  parse_mode_t mode;
  int unsigned cmd_cnt;
  int unsigned val_cnt;
  emit_t       pending_emits[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned end_bytes;

  function new();
    start_c    = 8'h23;
    sep_c      = 8'h3A;
    end_c      = 8'h40;
    mode       = PARSE_IDLE;
    cmd_cnt    = 0;
    val_cnt    = 0;
    mismatches = 0;
    checked    = 0;
    end_bytes  = 0;
    foreach (cmd_mem[i]) cmd_mem[i] = 8'h00;
    foreach (val_mem[i]) val_mem[i] = 8'h00;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] value);
    case (idx)
      dcfp_pkg::REG_START: start_c = value;
      dcfp_pkg::REG_SEP:   sep_c = value;
      dcfp_pkg::REG_END:   end_c = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_emits.size();
  endfunction

  // Notes one accepted input byte and queues whatever results it releases.
  function void take_rx_byte(logic [7:0] b);
    emit_t burst[$];
    emit_t e;
    if (b == end_c) begin
      mode    = PARSE_IDLE;
      cmd_cnt = 0;
      val_cnt = 0;
      end_bytes++;
      for (int i = 0; i + 1 < dcfp_pkg::CMD_CAP && cmd_mem[i] != 8'h00; i++) begin
        e.kind = dcfp_pkg::KIND_CMD;
        e.data = cmd_mem[i];
        e.last = 1'b0;
        burst.push_back(e);
      end
      for (int i = 0; i + 1 < dcfp_pkg::VAL_CAP && val_mem[i] != 8'h00; i++) begin
        e.kind = dcfp_pkg::KIND_VAL;
        e.data = val_mem[i];
        e.last = 1'b0;
        burst.push_back(e);
      end
      if (burst.size() == 0) begin
        e.kind = dcfp_pkg::KIND_EMPTY;
        e.data = 8'h00;
        e.last = 1'b1;
        burst.push_back(e);
      end else begin
        burst[burst.size() - 1].last = 1'b1;
      end
      foreach (burst[i]) pending_emits.push_back(burst[i]);
      return;
    end
    if (mode == PARSE_VAL && val_cnt + 1 < dcfp_pkg::VAL_CAP) begin
      val_mem[val_cnt] = b;
      val_cnt++;
    end
    if (b == sep_c) mode = PARSE_VAL;
    if (mode == PARSE_CMD && cmd_cnt + 1 < dcfp_pkg::CMD_CAP) begin
      cmd_mem[cmd_cnt] = b;
      cmd_cnt++;
    end
    if (b == start_c) begin
      mode    = PARSE_CMD;
      cmd_cnt = 0;
      val_cnt = 0;
      foreach (cmd_mem[i]) cmd_mem[i] = 8'h00;
      foreach (val_mem[i]) val_mem[i] = 8'h00;
    end
  endfunction

  // Compares one accepted result with the oldest expectation.
  function void check_emit(logic [1:0] kind, logic [7:0] data, logic last);
    emit_t want;
    if (pending_emits.size() == 0) begin
      $display("%0t: unexpected result kind=%0d byte=%02h last=%b", $time, kind, data, last);
      mismatches++;
      return;
    end
    want = pending_emits.pop_front();
    checked++;
    if (kind !== want.kind || data !== want.data || last !== want.last) begin
      $display("%0t: mismatch: want kind=%0d byte=%02h last=%b, got kind=%0d byte=%02h last=%b",
               $time, want.kind, want.data, want.last, kind, data, last);
      mismatches++;
    end
  endfunction
endclass

module delimited_command_frame_parser_test;
  import dcfp_pkg::*;

  // Index 3 is not a register; a write to it must leave all delimiters alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet time that lets queued store writes retire before a delimiter change.
  localparam int SETTLE_CYCLES = 40;
  localparam int SEGMENT_BYTES = 42;
  localparam int SEGMENTS = 6;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  emit_predictor sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 1;

  delimited_command_frame_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #6 clk = ~clk;

  // The receiver stalls at random with the probability of the current idling phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output monitor and watchdog. All inputs change through nonblocking assignments, so the
  // values read here are the ones that held just before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_emit(out_kind, out_byte, out_last);
    end
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still expected",
               $time, quiet_cycles, sb.pending());
      $display("** delimited_command_frame_parser: FAILED **");
      $finish;
    end
  end

  // Offers one byte, idling first at random, and returns at the edge where it is accepted.
  // Valid is left high so that a following byte can go out back to back.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_rx_byte(b);
    bytes_sent++;
  endtask

  // Stops the sender, waits until every expected result has come out and then lets the
  // queued store writes and clears retire, so that the delimiters may change safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delimiters(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e);
    cfg_write(REG_START, s);
    cfg_write(REG_SEP, p);
    cfg_write(REG_END, e);
    settings_used++;
  endtask

  // Data bytes lean toward zero and all ones, which stop or stress the string output.
  function automatic logic [7:0] rand_payload();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 12) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Mostly short strings; now and then one long enough to overflow its store.
  function automatic int pick_len(input int longest);
    if ($urandom_range(6) == 0) return $urandom_range(longest);
    return $urandom_range(4);
  endfunction

  // One random chunk of traffic. Most chunks are complete frames with random content; the
  // rest are stray bytes, frames cut short, lone end bytes and frames that reuse delimiters.
  task automatic send_frame();
    int shape;
    int n;
    shape = $urandom_range(99);
    if (shape < 70) begin
      send_byte(sb.start_c);
      n = pick_len(CMD_CAP + 4);
      repeat (n) send_byte(rand_payload());
      if ($urandom_range(4) != 0) begin
        send_byte(sb.sep_c);
        n = pick_len(VAL_CAP + 3);
        repeat (n) send_byte(rand_payload());
      end
      send_byte(sb.end_c);
    end else if (shape < 80) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (shape < 88) begin
      send_byte(sb.start_c);
      n = $urandom_range(0, 3);
      repeat (n) send_byte(rand_payload());
    end else if (shape < 93) begin
      send_byte(sb.end_c);
    end else begin
      send_byte(sb.start_c);
      repeat ($urandom_range(0, 2)) send_byte(rand_payload());
      send_byte(sb.sep_c);
      repeat ($urandom_range(0, 2)) send_byte(rand_payload());
      send_byte(sb.sep_c);
      if ($urandom_range(1) == 1) send_byte(sb.start_c);
      repeat ($urandom_range(0, 2)) send_byte(rand_payload());
      send_byte(sb.end_c);
    end
  endtask

  initial begin
    logic [7:0]  directed_seq [23];
    logic [7:0]  shared;
    int unsigned seg_base;

    sb = new();
    // The directed part runs in the first idling phase.
    send_idle_pct  = 19;
    recv_stall_pct = 64;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed traffic under the default delimiters:
    //   an end byte straight after reset gives the empty marker, a byte while idle is ignored,
    //   an empty frame, then a frame with a zero inside the command, a separator handled as
    //   value data, a value that overflows its store, a second end byte that replays the
    //   stores, and a start byte in value mode that wipes everything again.
    directed_seq = '{8'h40, 8'h55, 8'h23, 8'h40,
                     8'h23, 8'h41, 8'h00, 8'h42, 8'h3A, 8'hFF, 8'h3A,
                     8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h40,
                     8'h40, 8'h23, 8'h3A, 8'h23, 8'h40};
    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    // Random segments. Each pair of segments uses one idling phase, and every segment but
    // the first starts from a fresh delimiter setting, the extreme byte values among them.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: cfg_write(REG_UNUSED, 8'hA5);
        1: set_delimiters(8'h00, 8'hFF, 8'h80);
        2: set_delimiters(8'hFF, 8'h00, 8'h7F);
        3: set_delimiters(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        4: set_delimiters(8'h23, 8'h3A, 8'h40);
        default: begin
          // Start and separator share one byte value, so the start role has to win.
          shared = 8'($urandom_range(255));
          set_delimiters(shared, shared, shared ^ 8'($urandom_range(1, 255)));
        end
      endcase
      case (seg / 2)
        0: begin
          send_idle_pct  = 19;
          recv_stall_pct = 64;
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 19;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      seg_base = bytes_sent;
      while (bytes_sent - seg_base < SEGMENT_BYTES) send_frame();
    end

    // The end byte takes precedence over the start role when both share one value.
    settle();
    cfg_write(REG_END, sb.start_c);
    send_byte(sb.start_c);
    send_byte(rand_payload());
    send_byte(sb.sep_c);
    send_byte(sb.start_c);

    settle();
    $display("Sent %0d bytes including %0d end bytes under %0d delimiter settings;",
             bytes_sent, sb.end_bytes, settings_used);
    $display("checked %0d result transactions, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** delimited_command_frame_parser: PASSED **");
    end else begin
      $display("** delimited_command_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/dcfp_pkg.sv
rtl/dcfp_front.sv
rtl/dcfp_queue.sv
rtl/dcfp_back.sv
rtl/delimited_command_frame_parser.sv
tb/sv/delimited_command_frame_parser_test.sv
